FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BECHI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BECHI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bechi_pkg.sv
// ----------------------------------------------------------------------------
// bechi_pkg
// Types, constants and codes shared by the byte statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package bechi_pkg;

	localparam int COUNT_BITS_DEF = 24;

	localparam int LOG_IN_W  = 32;
	localparam int FRAC_W    = 16;
	localparam int EXP_W     = 5;
	localparam int LOG_W     = EXP_W + FRAC_W;
	localparam int SQ_STEPS  = FRAC_W;

	localparam int DIV_DW    = 72;
	localparam int DIV_VW    = 32;
	localparam int DIV_CW    = $clog2(DIV_DW);

	localparam int SUM_W     = 64;
	localparam int CHI_W     = 40;
	localparam int ENT_W     = 20;
	localparam int CNT_OUT_W = 24;
	localparam int DIST_W    = 9;
	localparam int MINLEN_W  = 16;

	localparam logic [ENT_W-1:0] ENT_MAX = 20'd524288;
	localparam logic [CNT_OUT_W-1:0] CNT_OUT_MAX = 24'hFFFFFF;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTROPY_THR = 2'd1;

	localparam logic [MINLEN_W-1:0] MIN_LENGTH_RST = 16'd32;
	localparam logic [ENT_W-1:0] ENT_THR_RST = 20'd478413;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0] byte_count;
		logic [DIST_W-1:0]    distinct_values;
		logic [ENT_W-1:0]     entropy_q16;
		logic [CHI_W-1:0]     chi_square_q8;
		logic                 too_short;
		logic                 entropy_above;
	} out_word_t;

	typedef struct packed {
		logic       acc;
		logic [7:0] acc_byte;
		logic       sweep_rd;
		logic [7:0] sweep_addr;
		logic       clear;
	} hist_ctl_t;

	typedef enum logic [1:0] {
		LOG_IDLE,
		LOG_NORM,
		LOG_SQ
	} log_st_t;

	typedef enum logic {
		DIV_IDLE,
		DIV_RUN
	} div_st_t;

	typedef enum logic [4:0] {
		S_ACC,
		S_DRAIN,
		S_P1_RD,
		S_P1_CHK,
		S_P1_LOG,
		S_P1_ACC,
		S_P1_NEXT,
		S_LT,
		S_LT_W,
		S_DV1,
		S_DV1_W,
		S_DV2,
		S_DV2_W,
		S_P2_RD,
		S_P2_CHK,
		S_P2_SQ,
		S_P2_ACC,
		S_P2_NEXT,
		S_DV3,
		S_DV3_W,
		S_FIN
	} seq_st_t;

endpackage

`default_nettype wire

FILE: rtl/bechi_log2.sv
// ----------------------------------------------------------------------------
// bechi_log2
// Iterative log2 in Q5.16: shift-normalize, then sixteen mantissa squarings.
// ----------------------------------------------------------------------------
`default_nettype none

module bechi_log2 import bechi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [LOG_IN_W-1:0] x,
	output logic                busy,
	output logic                done,
	output logic [LOG_W-1:0]    result
);

	log_st_t state_q, state_d;
	logic [LOG_IN_W-1:0]     m_q;
	logic [EXP_W-1:0]        e_q;
	logic [$clog2(SQ_STEPS)-1:0] k_q;
	logic [FRAC_W-1:0]       frac_q;
	logic                    done_q;
	logic [2*LOG_IN_W-1:0]   sq;
	logic [LOG_IN_W:0]       sq_hi;

	assign sq    = m_q * m_q;
	assign sq_hi = sq[2*LOG_IN_W-1:LOG_IN_W-1];

	always_comb begin
		state_d = state_q;
		case (state_q)
			LOG_IDLE: if (start && (x != '0)) state_d = LOG_NORM;
			LOG_NORM: if (m_q[LOG_IN_W-1]) state_d = LOG_SQ;
			LOG_SQ:   if (k_q == SQ_STEPS[$clog2(SQ_STEPS)-1:0] - 1'b1) state_d = LOG_IDLE;
			default:  state_d = LOG_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q != LOG_IDLE);
		done   = done_q;
		result = {e_q, frac_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOG_IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				LOG_IDLE: begin
					k_q <= '0;
					if (start && (x == '0)) done_q <= 1'b1;
				end
				LOG_SQ: begin
					k_q <= k_q + 1'b1;
					if (k_q == SQ_STEPS[$clog2(SQ_STEPS)-1:0] - 1'b1) done_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			LOG_IDLE: begin
				if (start) begin
					m_q    <= x;
					e_q    <= (x == '0) ? '0 : EXP_W'(LOG_IN_W - 1);
					frac_q <= '0;
				end
			end
			LOG_NORM: begin
				if (!m_q[LOG_IN_W-1]) begin
					m_q <= {m_q[LOG_IN_W-2:0], 1'b0};
					e_q <= e_q - 1'b1;
				end
			end
			LOG_SQ: begin
				frac_q <= {frac_q[FRAC_W-2:0], sq_hi[LOG_IN_W]};
				m_q    <= sq_hi[LOG_IN_W] ? sq_hi[LOG_IN_W:1] : sq_hi[LOG_IN_W-1:0];
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/bechi_div.sv
// ----------------------------------------------------------------------------
// bechi_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bechi_div import bechi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_DW-1:0] dividend,
	input  logic [DIV_VW-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [DIV_DW-1:0] quotient
);

	div_st_t state_q, state_d;
	logic [DIV_DW-1:0] q_q;
	logic [DIV_VW-1:0] r_q;
	logic [DIV_VW-1:0] v_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              done_q;
	logic [DIV_VW:0]   r2;
	logic              fits;

	assign r2   = {r_q, q_q[DIV_DW-1]};
	assign fits = (r2 >= {1'b0, v_q});

	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: if (start) state_d = DIV_RUN;
			DIV_RUN:  if (cnt_q == DIV_CW'(DIV_DW - 1)) state_d = DIV_IDLE;
			default:  state_d = DIV_IDLE;
		endcase
	end

	always_comb begin
		busy     = (state_q == DIV_RUN);
		done     = done_q;
		quotient = q_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DIV_RUN) && (cnt_q == DIV_CW'(DIV_DW - 1));
			cnt_q   <= (state_q == DIV_RUN) ? cnt_q + 1'b1 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && start) begin
			q_q <= dividend;
			r_q <= '0;
			v_q <= divisor;
		end else if (state_q == DIV_RUN) begin
			q_q <= {q_q[DIV_DW-2:0], fits};
			r_q <= fits ? DIV_VW'(r2 - {1'b0, v_q}) : r2[DIV_VW-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bechi_hist.sv
// ----------------------------------------------------------------------------
// bechi_hist
// Bin memory with per-entry valid bits, increment read-modify-write and sweep read.
// ----------------------------------------------------------------------------
`default_nettype none

module bechi_hist import bechi_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hist_ctl_t             ctl,
	output logic [COUNT_BITS-1:0] cnt
);

	`include "assert_macros.svh"

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [COUNT_BITS-1:0] mem [256];
	logic [255:0]          vld_q;
	logic [COUNT_BITS-1:0] rdata_s1;
	logic                  rvld_s1;
	logic                  acc_s1;
	logic [7:0]            addr_s1;
	logic                  wr_vld_q;
	logic [7:0]            wr_addr_q;
	logic [COUNT_BITS-1:0] wr_data_q;
	logic [7:0]            raddr;
	logic                  rd_en;
	logic [COUNT_BITS-1:0] old_cnt;
	logic [COUNT_BITS-1:0] new_cnt;

	assign raddr = ctl.acc ? ctl.acc_byte : ctl.sweep_addr;
	assign rd_en = ctl.acc || ctl.sweep_rd;

	always_comb begin
		if (wr_vld_q && (wr_addr_q == addr_s1)) old_cnt = wr_data_q;
		else if (rvld_s1) old_cnt = rdata_s1;
		else old_cnt = '0;
		new_cnt = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + 1'b1;
		cnt     = rvld_s1 ? rdata_s1 : '0;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rdata_s1 <= mem[raddr];
		if (acc_s1) mem[addr_s1] <= new_cnt;
		if (acc_s1) wr_data_q <= new_cnt;
		wr_addr_q <= addr_s1;
		addr_s1   <= raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rvld_s1  <= 1'b0;
			acc_s1   <= 1'b0;
			wr_vld_q <= 1'b0;
		end else begin
			acc_s1   <= ctl.acc;
			wr_vld_q <= acc_s1;
			if (rd_en) rvld_s1 <= vld_q[raddr];
			if (ctl.clear) vld_q <= '0;
			else if (acc_s1) vld_q[addr_s1] <= 1'b1;
		end
	end

	`BECHI_ASSERT_IMP(a_one_port_user, ctl.acc, !ctl.sweep_rd, "sweep read during accumulate")
	`BECHI_ASSERT_IMP(a_clear_quiet, ctl.clear, !acc_s1 && !ctl.acc, "clear during accumulate")
	`BECHI_ASSERT_NXT(a_write_marks, acc_s1 && !ctl.clear, vld_q[$past(addr_s1)], "bin not marked")

endmodule

`default_nettype wire

FILE: rtl/byte_entropy_chi_square_test.sv
// ----------------------------------------------------------------------------
// byte_entropy_chi_square_test
// Byte histogram of one file with Shannon entropy and chi-square at its end.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle into a 256-entry bin memory (increment with
// write forwarding). The word with last set starts an end-of-file pass during
// which in_ready stays low: a first sweep over the bins takes the log2 of each
// filled bin (log2 unit: up to 31 normalizing steps plus 16 squarings), then
// one log2 and two divisions, a second sweep summing the squared deviations of
// the filled bins from their average, and a last division. The result sits in
// an output register, so the next file may stream in while it waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_entropy_chi_square_test import bechi_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	`include "assert_macros.svh"

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	seq_st_t state_q, state_d;
	hist_ctl_t              hctl;
	logic [COUNT_BITS-1:0]  cnt;
	logic [MINLEN_W-1:0]    min_len_q;
	logic [ENT_W-1:0]       ent_thr_q;
	logic [COUNT_BITS-1:0]  total_q;
	logic [7:0]             idx_q;
	logic [COUNT_BITS-1:0]  c_q;
	logic [DIST_W-1:0]      distinct_q;
	logic [SUM_W-1:0]       s_q;
	logic [SUM_W-1:0]       prod_q;
	logic [LOG_W-1:0]       lt_q;
	logic [ENT_W-1:0]       ent_q;
	logic [COUNT_BITS-1:0]  avg_q;
	logic [COUNT_BITS-1:0]  diff_q;
	logic [SUM_W-1:0]       sq_q;
	logic [SUM_W-1:0]       d_q;
	logic [CHI_W-1:0]       chi_q;
	logic                   out_vld_q;
	out_word_t              out_q;
	logic                   accept;
	logic                   out_load;
	logic                   log_start, log_busy, log_done;
	logic [LOG_IN_W-1:0]    log_x;
	logic [LOG_W-1:0]       log_res;
	logic                   div_start, div_busy, div_done;
	logic [DIV_DW-1:0]      div_num;
	logic [DIV_VW-1:0]      div_den;
	logic [DIV_DW-1:0]      div_quot;
	logic [COUNT_BITS+LOG_W-1:0] prod_w;
	logic [2*COUNT_BITS-1:0] sq_w;
	logic [SUM_W:0]          d_sum;
	logic [LOG_W-1:0]        ent_raw;
	logic [31:0]             total32;

	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == S_FIN) && (!out_vld_q || out_ready);
	assign prod_w   = c_q * log_res;
	assign sq_w     = diff_q * diff_q;
	assign d_sum    = {1'b0, d_q} + {1'b0, sq_q};
	assign total32  = 32'(total_q);
	assign ent_raw  = (DIV_DW'(lt_q) > div_quot) ? lt_q - div_quot[LOG_W-1:0] : '0;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_ACC:     if (accept && in_data.last) state_d = S_DRAIN;
			S_DRAIN:   state_d = S_P1_RD;
			S_P1_RD:   state_d = S_P1_CHK;
			S_P1_CHK:  state_d = (cnt != '0) ? S_P1_LOG : S_P1_NEXT;
			S_P1_LOG:  if (log_done) state_d = S_P1_ACC;
			S_P1_ACC:  state_d = S_P1_NEXT;
			S_P1_NEXT: state_d = (idx_q == 8'hFF) ? S_LT : S_P1_RD;
			S_LT:      state_d = S_LT_W;
			S_LT_W:    if (log_done) state_d = S_DV1;
			S_DV1:     state_d = S_DV1_W;
			S_DV1_W:   if (div_done) state_d = S_DV2;
			S_DV2:     state_d = S_DV2_W;
			S_DV2_W:   if (div_done) state_d = S_P2_RD;
			S_P2_RD:   state_d = S_P2_CHK;
			S_P2_CHK:  state_d = (cnt != '0) ? S_P2_SQ : S_P2_NEXT;
			S_P2_SQ:   state_d = S_P2_ACC;
			S_P2_ACC:  state_d = S_P2_NEXT;
			S_P2_NEXT: state_d = (idx_q == 8'hFF) ? S_DV3 : S_P2_RD;
			S_DV3:     state_d = (avg_q == '0) ? S_FIN : S_DV3_W;
			S_DV3_W:   if (div_done) state_d = S_FIN;
			S_FIN:     if (out_load) state_d = S_ACC;
			default:   state_d = S_ACC;
		endcase
	end

	always_comb begin
		in_ready        = (state_q == S_ACC);
		cfg_ready       = 1'b1;
		hctl.acc        = accept;
		hctl.acc_byte   = in_data.data_byte;
		hctl.sweep_rd   = (state_q == S_P1_RD) || (state_q == S_P2_RD);
		hctl.sweep_addr = idx_q;
		hctl.clear      = out_load;
		log_start       = ((state_q == S_P1_CHK) && (cnt != '0)) || (state_q == S_LT);
		log_x           = (state_q == S_LT) ? total32 : 32'(cnt);
		div_start       = (state_q == S_DV1) || (state_q == S_DV2)
		                  || ((state_q == S_DV3) && (avg_q != '0));
		case (state_q)
			S_DV1: begin
				div_num = DIV_DW'(s_q);
				div_den = total32;
			end
			S_DV2: begin
				div_num = DIV_DW'(total_q);
				div_den = DIV_VW'(distinct_q);
			end
			default: begin
				div_num = {d_q, 8'h00};
				div_den = DIV_VW'(avg_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_ACC;
			min_len_q <= MIN_LENGTH_RST;
			ent_thr_q <= ENT_THR_RST;
			total_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MIN_LENGTH:  min_len_q <= cfg_data[MINLEN_W-1:0];
					CFG_ENTROPY_THR: ent_thr_q <= cfg_data[ENT_W-1:0];
					default: ;
				endcase
			end
			if (out_load) total_q <= '0;
			else if (accept && (total_q != CNT_MAX)) total_q <= total_q + 1'b1;
			if (out_load) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_DRAIN: begin
				idx_q      <= '0;
				distinct_q <= '0;
				s_q        <= '0;
			end
			S_P1_CHK: begin
				c_q <= cnt;
				if (cnt != '0) distinct_q <= distinct_q + 1'b1;
			end
			S_P1_LOG:  if (log_done) prod_q <= SUM_W'(prod_w);
			S_P1_ACC:  s_q <= s_q + prod_q;
			S_P1_NEXT: idx_q <= idx_q + 1'b1;
			S_LT_W:    if (log_done) lt_q <= log_res;
			S_DV1_W: begin
				if (div_done) begin
					ent_q <= (ent_raw > LOG_W'(ENT_MAX)) ? ENT_MAX : ent_raw[ENT_W-1:0];
				end
			end
			S_DV2_W: begin
				if (div_done) begin
					avg_q <= div_quot[COUNT_BITS-1:0];
					idx_q <= '0;
					d_q   <= '0;
				end
			end
			S_P2_CHK:  diff_q <= (cnt > avg_q) ? cnt - avg_q : avg_q - cnt;
			S_P2_SQ:   sq_q <= SUM_W'(sq_w);
			S_P2_ACC:  d_q <= d_sum[SUM_W] ? '1 : d_sum[SUM_W-1:0];
			S_P2_NEXT: idx_q <= idx_q + 1'b1;
			S_DV3:     if (avg_q == '0) chi_q <= '1;
			S_DV3_W: begin
				if (div_done) chi_q <= (|div_quot[DIV_DW-1:CHI_W]) ? '1 : div_quot[CHI_W-1:0];
			end
			default: ;
		endcase
		if (out_load) begin
			out_q.byte_count      <= (total32 > 32'(CNT_OUT_MAX)) ? CNT_OUT_MAX
			                         : total32[CNT_OUT_W-1:0];
			out_q.distinct_values <= distinct_q;
			out_q.entropy_q16     <= ent_q;
			out_q.chi_square_q8   <= chi_q;
			out_q.too_short       <= (total32 < 32'(min_len_q));
			out_q.entropy_above   <= (ent_q > ent_thr_q);
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	bechi_hist #(
		.COUNT_BITS(COUNT_BITS)
	) u_hist (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (hctl),
		.cnt   (cnt)
	);

	bechi_log2 u_log2 (
		.clk   (clk),
		.arst_n(arst_n),
		.start (log_start),
		.x     (log_x),
		.busy  (log_busy),
		.done  (log_done),
		.result(log_res)
	);

	bechi_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_num),
		.divisor (div_den),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_quot)
	);

	`BECHI_ASSERT_IMP(a_div_free, div_start, !div_busy, "divider started while busy")
	`BECHI_ASSERT_IMP(a_log_free, log_start, !log_busy, "log2 started while busy")
	`BECHI_ASSERT_NXT(a_out_load, out_load, out_vld_q && (total_q == '0), "result load lost")

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte statistics block testbench
// Streams files of bytes through the block and checks each end-of-file result
// (count, distinct values, entropy, chi-square, flags) against a predictor
// kept in step with every accepted byte and register write.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import bechi_pkg::*;

	localparam logic [63:0] BIN_MAX = 64'hFFFFFF;
	localparam logic [63:0] CHI_SAT = 64'hFF_FFFF_FFFF;
	localparam int WATCHDOG_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [63:0] hist [256];
	logic [63:0] file_total;
	logic [63:0] min_len_reg;
	logic [63:0] ent_thr_reg;
	out_word_t stats_queue [$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_off = 0;
	int errors = 0;
	int quiet_cycles = 0;

	always #2 clk = ~clk;

	byte_entropy_chi_square_test u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic logic [63:0] log2_fix(input logic [63:0] x);
		logic [63:0] m;
		logic [63:0] frac;
		int e;
		frac = 0;
		e = 0;
		x = x & 64'hFFFFFFFF;
		if (x == 0) return 0;
		while (e < 31 && (x >> (e + 1)) != 0) e++;
		m = x << (31 - e);
		for (int k = 0; k < 16; k++) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				frac[15 - k] = 1'b1;
				m = m >> 1;
			end
		end
		return (64'(e) << 16) | frac;
	endfunction

	function automatic void count_byte(input logic [7:0] b, input logic is_last);
		logic [63:0] t, s, ls, ent, avg, d, chi, c, diff, sq, q, r;
		int distinct;
		out_word_t w;
		s = 0;
		d = 0;
		distinct = 0;
		if (hist[b] < BIN_MAX) hist[b]++;
		if (file_total < BIN_MAX) file_total++;
		if (!is_last) return;
		t = file_total;
		for (int i = 0; i < 256; i++)
			if (hist[i] != 0) begin
				distinct++;
				s += hist[i] * log2_fix(hist[i]);
			end
		ls = s / t;
		ent = log2_fix(t);
		ent = (ent > ls) ? ent - ls : 0;
		if (ent > 524288) ent = 524288;
		avg = t / distinct;
		if (avg == 0) begin
			chi = CHI_SAT;
		end else begin
			for (int i = 0; i < 256; i++) begin
				c = hist[i];
				if (c != 0) begin
					diff = (c > avg) ? c - avg : avg - c;
					sq = diff * diff;
					d = (d > ~64'h0 - sq) ? ~64'h0 : d + sq;
				end
			end
			q = d / avg;
			r = d % avg;
			if (q > (CHI_SAT >> 8)) chi = CHI_SAT;
			else begin
				chi = (q << 8) + ((r << 8) / avg);
				if (chi > CHI_SAT) chi = CHI_SAT;
			end
		end
		w.byte_count = CNT_OUT_W'(t);
		w.distinct_values = DIST_W'(distinct);
		w.entropy_q16 = ENT_W'(ent);
		w.chi_square_q8 = CHI_W'(chi);
		w.too_short = t < min_len_reg;
		w.entropy_above = ent > ent_thr_reg;
		stats_queue.push_back(w);
		for (int i = 0; i < 256; i++) hist[i] = 0;
		file_total = 0;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic is_last);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, last: is_last};
		do @(posedge clk); while (!in_ready);
		count_byte(b, is_last);
	endtask

	task automatic send_file(input int len, input int mode);
		logic [7:0] base;
		base = 8'($urandom);
		for (int i = 0; i < len; i++)
			case (mode)
				0: send_byte(8'($urandom), i == len - 1);
				1: send_byte(base, i == len - 1);
				2: send_byte(base + 8'($urandom_range(3)), i == len - 1);
				default: send_byte(8'(i), i == len - 1);
			endcase
	endtask

	task automatic wait_idle;
		in_valid <= 1'b0;
		while (stats_queue.size() != 0) @(posedge clk);
		repeat (20000) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_MIN_LENGTH) min_len_reg = val & 64'hFFFF;
		else if (idx == CFG_ENTROPY_THR) ent_thr_reg = val & 64'hFFFFF;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= !($urandom_range(99) < recv_idle_pct);
		if (out_valid && out_ready) begin
			if (stats_queue.size() == 0) begin
				$error("result with none expected");
				errors++;
			end else begin
				automatic out_word_t e = stats_queue.pop_front();
				if (out_data.byte_count !== e.byte_count) begin
					$error("byte_count exp %0d got %0d", e.byte_count, out_data.byte_count);
					errors++;
				end
				if (out_data.distinct_values !== e.distinct_values) begin
					$error("distinct_values exp %0d got %0d", e.distinct_values,
						out_data.distinct_values);
					errors++;
				end
				if (out_data.entropy_q16 !== e.entropy_q16) begin
					$error("entropy_q16 exp %0d got %0d", e.entropy_q16, out_data.entropy_q16);
					errors++;
				end
				if (out_data.chi_square_q8 !== e.chi_square_q8) begin
					$error("chi_square_q8 exp %0d got %0d", e.chi_square_q8,
						out_data.chi_square_q8);
					errors++;
				end
				if (out_data.too_short !== e.too_short) begin
					$error("too_short exp %0d got %0d", e.too_short, out_data.too_short);
					errors++;
				end
				if (out_data.entropy_above !== e.entropy_above) begin
					$error("entropy_above exp %0d got %0d", e.entropy_above,
						out_data.entropy_above);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic test_edges;
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_file(31, 1);
		send_file(32, 1);
		send_file(256, 3);
		send_file(12, 2);
	endtask

	task automatic test_config;
		wait_idle();
		write_reg(CFG_MIN_LENGTH, 1);
		write_reg(CFG_ENTROPY_THR, 0);
		send_file(5, 0);
		send_byte(8'hA5, 1'b1);
		wait_idle();
		write_reg(CFG_MIN_LENGTH, 65535);
		write_reg(CFG_ENTROPY_THR, 524288);
		send_file(20, 3);
		wait_idle();
		write_reg(CFG_MIN_LENGTH, 40);
		write_reg(CFG_ENTROPY_THR, 200000);
	endtask

	task automatic test_backpressure;
		hold_off = 12000;
		for (int f = 0; f < 4; f++) send_file(6, 0);
	endtask

	task automatic test_random;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 54 : 0;
			recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 37 : 0;
			for (int f = 0; f < 4; f++)
				send_file($urandom_range(1, 28), $urandom_range(3));
			if (phase == 1) begin
				wait_idle();
				write_reg(CFG_MIN_LENGTH, $urandom_range(1, 30));
				write_reg(CFG_ENTROPY_THR, $urandom_range(524288));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < 256; i++) hist[i] = 0;
		file_total = 0;
		min_len_reg = 32;
		ent_thr_reg = 478413;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges();
		test_config();
		test_backpressure();
		test_random();
		wait_idle();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

`default_nettype wire
